>>> rtl/bfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bfr_pkg;

   localparam int unsigned LENGTH_BITS_DEFAULT = 32;

   localparam logic [15:0] HUNT_LIMIT_RESET = 16'd1000;
   localparam logic [31:0] MAX_LENGTH_RESET = 32'd1048576;

   localparam logic [31:0] MARKER   = {8'h49, 8'h4D, 8'h47, 8'h58};
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic [2:0] KIND_PAYLOAD    = 3'd0;
   localparam logic [2:0] KIND_ACCEPTED   = 3'd1;
   localparam logic [2:0] KIND_BAD_HEADER = 3'd2;
   localparam logic [2:0] KIND_TOO_LARGE  = 3'd3;
   localparam logic [2:0] KIND_CRC_ERROR  = 3'd4;

   localparam logic CSR_HUNT_LIMIT = 1'b0;
   localparam logic CSR_MAX_LENGTH = 1'b1;

   typedef enum logic [3:0] {
      PH_HUNT    = 4'b0001,
      PH_LEN     = 4'b0010,
      PH_PAYLOAD = 4'b0100,
      PH_CRC     = 4'b1000
   } phase_type;

endpackage
`default_nettype wire

>>> rtl/bfr_crc32_byte.sv
`timescale 1ns / 1ps
`default_nettype none
module bfr_crc32_byte (
   input  wire logic [31:0] crc_in,
   input  wire logic [7:0]  data,
   output logic [31:0]      crc_out
);
   import bfr_pkg::*;

   always_comb begin
      logic [31:0] c;
      c = crc_in ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      crc_out = c;
   end

endmodule
`default_nettype wire

>>> rtl/boot_image_frame_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// Boot image frame receiver: takes one received byte per beat, hunts for the
// "IMGX" marker, reads a little-endian length, passes payload bytes through
// while running a reflected CRC-32, then reads a little-endian CRC and gives a
// verdict (accepted, bad header, too large, crc mismatch). A byte goes into an
// input register and is processed by one pass of byte-wide logic (one CRC
// byte update, one 32-bit compare) into the result register, so one byte is
// taken every cycle as long as results are drained; a stalled result stops
// intake only once both registers are full. Marker, length (unless too large)
// and the first three CRC bytes produce no result beat. Write hunt_limit and
// max_length through the csr port only while no frame is in flight.
module boot_image_frame_receiver #(
   parameter int unsigned LENGTH_BITS = bfr_pkg::LENGTH_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_rx_byte,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [7:0]       rsp_data_byte,
   output logic [31:0]      rsp_frame_length,
   output logic             rsp_end_of_frame,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import bfr_pkg::*;

   // configuration
   logic [15:0] hunt_limit_ff, hunt_limit_in;
   logic [31:0] max_length_ff, max_length_in;

   // input stage
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        advance;

   // frame state
   phase_type              phase_ff, phase_in;
   logic [31:0]            window_ff, window_in;
   logic [15:0]            hunt_count_ff, hunt_count_in;
   logic [1:0]             index_ff, index_in;
   logic [31:0]            length_ff, length_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic [31:0]            crc_ff, crc_in;
   logic [31:0]            rx_crc_ff, rx_crc_in;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [2:0]  out_kind_ff, out_kind_in;
   logic [7:0]  out_data_ff, out_data_in;
   logic [31:0] out_length_ff, out_length_in;
   logic        out_eof_ff, out_eof_in;

   logic [31:0] crc_next;
   logic [31:0] window_shift;
   logic [15:0] count_inc;
   logic [31:0] length_or;
   logic [31:0] rx_crc_or;
   logic [LENGTH_BITS-1:0] remaining_dec;
   logic        emit;
   logic        too_large;

   bfr_crc32_byte u_crc (
      .crc_in  (crc_ff),
      .data    (in_byte_ff),
      .crc_out (crc_next)
   );

   assign csr_ready = 1'b1;
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      hunt_limit_in = hunt_limit_ff;
      max_length_in = max_length_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_HUNT_LIMIT: hunt_limit_in = csr_data[15:0];
            CSR_MAX_LENGTH: max_length_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   assign window_shift  = {window_ff[23:0], in_byte_ff};
   assign count_inc     = (hunt_count_ff == 16'hFFFF) ? hunt_count_ff : hunt_count_ff + 16'd1;
   assign length_or     = length_ff | (32'(in_byte_ff) << {index_ff, 3'b000});
   assign rx_crc_or     = rx_crc_ff | (32'(in_byte_ff) << {index_ff, 3'b000});
   assign remaining_dec = (remaining_ff != '0) ? remaining_ff - LENGTH_BITS'(1) : remaining_ff;
   assign too_large     = ((64'(length_or) >> LENGTH_BITS) != 64'd0) ||
                          (length_or > max_length_ff);

   always_comb begin
      phase_in      = phase_ff;
      window_in     = window_ff;
      hunt_count_in = hunt_count_ff;
      index_in      = index_ff;
      length_in     = length_ff;
      remaining_in  = remaining_ff;
      crc_in        = crc_ff;
      rx_crc_in     = rx_crc_ff;
      emit          = 1'b0;
      out_kind_in   = out_kind_ff;
      out_data_in   = out_data_ff;
      out_length_in = out_length_ff;
      out_eof_in    = out_eof_ff;

      if (advance) begin
         case (phase_ff)
            PH_HUNT: begin
               window_in     = window_shift;
               hunt_count_in = count_inc;
               if (window_shift == MARKER) begin
                  phase_in      = PH_LEN;
                  index_in      = 2'd0;
                  length_in     = 32'd0;
                  window_in     = 32'd0;
                  hunt_count_in = 16'd0;
               end else if (count_inc >= hunt_limit_ff) begin
                  window_in     = 32'd0;
                  hunt_count_in = 16'd0;
                  index_in      = 2'd0;
                  emit          = 1'b1;
                  out_kind_in   = KIND_BAD_HEADER;
                  out_data_in   = 8'd0;
                  out_length_in = 32'd0;
                  out_eof_in    = 1'b1;
               end
            end
            PH_LEN: begin
               length_in = length_or;
               if (index_ff != 2'd3) begin
                  index_in = index_ff + 2'd1;
               end else begin
                  index_in = 2'd0;
                  if (too_large) begin
                     phase_in      = PH_HUNT;
                     window_in     = 32'd0;
                     hunt_count_in = 16'd0;
                     emit          = 1'b1;
                     out_kind_in   = KIND_TOO_LARGE;
                     out_data_in   = 8'd0;
                     out_length_in = length_or;
                     out_eof_in    = 1'b1;
                  end else begin
                     crc_in       = CRC_INIT;
                     rx_crc_in    = 32'd0;
                     remaining_in = length_or[LENGTH_BITS-1:0];
                     phase_in     = (length_or == 32'd0) ? PH_CRC : PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               crc_in       = crc_next;
               remaining_in = remaining_dec;
               if (remaining_dec == '0) begin
                  phase_in  = PH_CRC;
                  index_in  = 2'd0;
                  rx_crc_in = 32'd0;
               end
               emit          = 1'b1;
               out_kind_in   = KIND_PAYLOAD;
               out_data_in   = in_byte_ff;
               out_length_in = 32'd0;
               out_eof_in    = 1'b0;
            end
            PH_CRC: begin
               rx_crc_in = rx_crc_or;
               if (index_ff != 2'd3) begin
                  index_in = index_ff + 2'd1;
               end else begin
                  phase_in      = PH_HUNT;
                  window_in     = 32'd0;
                  hunt_count_in = 16'd0;
                  index_in      = 2'd0;
                  emit          = 1'b1;
                  out_kind_in   = ((crc_ff ^ CRC_INIT) == rx_crc_or) ? KIND_ACCEPTED
                                                                     : KIND_CRC_ERROR;
                  out_data_in   = 8'd0;
                  out_length_in = length_ff;
                  out_eof_in    = 1'b1;
               end
            end
            default: begin
               phase_in      = PH_HUNT;
               window_in     = 32'd0;
               hunt_count_in = 16'd0;
               index_in      = 2'd0;
            end
         endcase
      end

      if (advance) begin
         out_valid_in = emit;
      end else begin
         out_valid_in = out_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hunt_limit_ff <= HUNT_LIMIT_RESET;
         max_length_ff <= MAX_LENGTH_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_HUNT;
         window_ff     <= 32'd0;
         hunt_count_ff <= 16'd0;
         index_ff      <= 2'd0;
         length_ff     <= 32'd0;
         remaining_ff  <= '0;
         crc_ff        <= CRC_INIT;
         rx_crc_ff     <= 32'd0;
      end else begin
         hunt_limit_ff <= hunt_limit_in;
         max_length_ff <= max_length_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         phase_ff      <= phase_in;
         window_ff     <= window_in;
         hunt_count_ff <= hunt_count_in;
         index_ff      <= index_in;
         length_ff     <= length_in;
         remaining_ff  <= remaining_in;
         crc_ff        <= crc_in;
         rx_crc_ff     <= rx_crc_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      out_kind_ff   <= out_kind_in;
      out_data_ff   <= out_data_in;
      out_length_ff <= out_length_in;
      out_eof_ff    <= out_eof_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_kind         = out_kind_ff;
   assign rsp_data_byte    = out_data_ff;
   assign rsp_frame_length = out_length_ff;
   assign rsp_end_of_frame = out_eof_ff;

   // payload beats never close a frame
   a_payload_shape: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_PAYLOAD) |-> (!out_eof_ff && out_length_ff == 32'd0))
      else $error("payload beat with verdict fields set");

   // bad header carries no length
   a_bad_header_len: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_BAD_HEADER) |-> (out_length_ff == 32'd0))
      else $error("bad header with nonzero length");

   // payload phase always has bytes left
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remaining_ff != '0))
      else $error("payload phase with zero bytes remaining");

   // byte index only counts in length and crc fields
   a_index_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HUNT || phase_ff == PH_PAYLOAD) |-> (index_ff == 2'd0))
      else $error("field index nonzero outside length or crc field");

   // an input beat without a result leaves the output register drained
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (advance && !emit) |=> !out_valid_ff)
      else $error("result beat appeared without a cause");

endmodule
`default_nettype wire

>>> dv/frame_checker.sv
`timescale 1ns / 1ps
package frame_crc_pkg;

   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ bfr_pkg::CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

module frame_checker #(
   parameter int unsigned LENGTH_BITS = bfr_pkg::LENGTH_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_kind,
   input  logic [7:0]  rsp_data_byte,
   input  logic [31:0] rsp_frame_length,
   input  logic        rsp_end_of_frame,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          fail_count,
   output int          pending,
   output logic        framing
);
   import bfr_pkg::*;
   import frame_crc_pkg::*;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  data_byte;
      logic [31:0] frame_length;
      logic        end_of_frame;
   } beat_t;

   beat_t       due_beats[$];
   logic [15:0] hunt_limit;
   logic [31:0] max_length;
   phase_type   phase;
   logic [31:0] window;
   logic [15:0] hunt_count;
   logic [1:0]  field_index;
   logic [31:0] frame_len;
   logic [31:0] remaining;
   logic [31:0] running_crc;
   logic [31:0] rx_crc;
   beat_t       got;
   beat_t       want;

   initial begin
      fail_count = 0;
      pending = 0;
      framing = 1'b0;
   end

   task automatic restart_hunt();
      phase = PH_HUNT;
      window = '0;
      hunt_count = '0;
      field_index = '0;
   endtask

   task automatic emit(input logic [2:0] kind, input logic [7:0] data, input logic [31:0] len,
                       input logic eof);
      beat_t b;
      b.kind = kind;
      b.data_byte = data;
      b.frame_length = len;
      b.end_of_frame = eof;
      due_beats.push_back(b);
   endtask

   task automatic take_byte(input logic [7:0] b);
      case (phase)
         PH_HUNT: begin
            window = {window[23:0], b};
            if (hunt_count != 16'hFFFF) begin
               hunt_count = hunt_count + 16'd1;
            end
            // marker wins over the limit on the same byte
            if (window == MARKER) begin
               phase = PH_LEN;
               field_index = '0;
               frame_len = '0;
               window = '0;
               hunt_count = '0;
            end else if (hunt_count >= hunt_limit) begin
               restart_hunt();
               emit(KIND_BAD_HEADER, 8'd0, 32'd0, 1'b1);
            end
         end
         PH_LEN: begin
            frame_len[8 * field_index +: 8] = b;
            if (field_index != 2'd3) begin
               field_index = field_index + 2'd1;
            end else if ((64'(frame_len) >> LENGTH_BITS) != 0 || frame_len > max_length) begin
               restart_hunt();
               emit(KIND_TOO_LARGE, 8'd0, frame_len, 1'b1);
            end else begin
               field_index = '0;
               running_crc = CRC_INIT;
               rx_crc = '0;
               remaining = frame_len;
               phase = (frame_len == 0) ? PH_CRC : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            running_crc = crc32_update(running_crc, b);
            if (remaining != 0) begin
               remaining = remaining - 32'd1;
            end
            if (remaining == 0) begin
               phase = PH_CRC;
               field_index = '0;
               rx_crc = '0;
            end
            emit(KIND_PAYLOAD, b, 32'd0, 1'b0);
         end
         PH_CRC: begin
            rx_crc[8 * field_index +: 8] = b;
            if (field_index != 2'd3) begin
               field_index = field_index + 2'd1;
            end else begin
               restart_hunt();
               emit((~running_crc == rx_crc) ? KIND_ACCEPTED : KIND_CRC_ERROR, 8'd0, frame_len,
                    1'b1);
            end
         end
         default: begin
            restart_hunt();
         end
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         hunt_limit = HUNT_LIMIT_RESET;
         max_length = MAX_LENGTH_RESET;
         restart_hunt();
         frame_len = '0;
         remaining = '0;
         running_crc = CRC_INIT;
         rx_crc = '0;
         due_beats.delete();
      end else begin
         // a result beat never belongs to the byte taken at the same edge
         if (rsp_valid && rsp_ready) begin
            got = {rsp_kind, rsp_data_byte, rsp_frame_length, rsp_end_of_frame};
            if (due_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) begin
                  $display("%0t unexpected beat: kind %0d data %h length %h eof %b",
                           $time, got.kind, got.data_byte, got.frame_length, got.end_of_frame);
               end
            end else begin
               want = due_beats.pop_front();
               if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                   got.frame_length !== want.frame_length ||
                   got.end_of_frame !== want.end_of_frame) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t mismatch: expected kind %0d data %h length %h eof %b",
                              $time, want.kind, want.data_byte, want.frame_length,
                              want.end_of_frame);
                     $display("%0t          actual   kind %0d data %h length %h eof %b",
                              $time, got.kind, got.data_byte, got.frame_length,
                              got.end_of_frame);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_HUNT_LIMIT) begin
               hunt_limit = csr_data[15:0];
            end else begin
               max_length = csr_data;
            end
         end
         if (req_valid && req_ready) begin
            take_byte(req_rx_byte);
         end
      end
      pending = due_beats.size();
      framing = (phase != PH_HUNT);
   end

endmodule

>>> dv/boot_image_frame_receiver_tb.sv
`timescale 1ns / 1ps
module boot_image_frame_receiver_tb;
   import bfr_pkg::*;
   import frame_crc_pkg::*;

   localparam int ITEMS          = 1600;
   localparam int RANDOM_ROUNDS  = 6;
   localparam int SETTLE_CYCLES  = 4;
   localparam int TAIL_CYCLES    = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic [31:0] rsp_frame_length;
   logic        rsp_end_of_frame;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_HUNT_LIMIT;
   logic [31:0] csr_data = 32'd0;

   int          fail_count;
   int          pending;
   logic        framing;

   logic [7:0]  stream[$];
   logic [31:0] max_cfg = MAX_LENGTH_RESET;
   int          bytes_sent = 0;
   bit          req_calm = 1'b0;
   bit          rsp_calm = 1'b0;
   int          rsp_hold = 0;
   int          rsp_stall;
   int          idle_cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   boot_image_frame_receiver uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   frame_checker beat_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_length (rsp_frame_length),
      .rsp_end_of_frame (rsp_end_of_frame),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .pending          (pending),
      .framing          (framing)
   );

   // result side back-pressure, one draw per beat
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         if (rsp_hold == 1) begin
            rsp_ready <= 1'b1;
         end
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 39) == 0) begin
            rsp_calm = !rsp_calm;
         end
         rsp_stall = rsp_calm ? 0 : $urandom_range(0, 6);
         if (rsp_stall != 0) begin
            rsp_ready <= 1'b0;
            rsp_hold <= rsp_stall;
         end
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("boot_image_frame_receiver_tb: errors");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int gap;
      if ($urandom_range(0, 39) == 0) begin
         req_calm = !req_calm;
      end
      gap = req_calm ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic drain_stream();
      while (stream.size() != 0) begin
         send_byte(stream.pop_front());
      end
   endtask

   // bring the receiver back to hunting and let every verdict drain
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (framing) begin
         send_byte($urandom_range(0, 255));
         req_valid <= 1'b0;
         @(posedge clock);
      end
      while (pending != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_regs(input logic [31:0] hunt_word, input logic [31:0] max_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_HUNT_LIMIT;
      csr_data <= hunt_word;
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_MAX_LENGTH;
      csr_data <= max_word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_cfg = max_word;
   endtask

   function automatic void add_marker(input int n);
      for (int i = 3; i > 3 - n; i--) begin
         stream.push_back(MARKER[8 * i +: 8]);
      end
   endfunction

   function automatic void add_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) begin
         stream.push_back(w[8 * i +: 8]);
      end
   endfunction

   // no closing marker byte, so noise alone never frames
   function automatic void add_noise(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         b = $urandom_range(0, 255);
         if (b == MARKER[7:0]) begin
            b = ~b;
         end
         stream.push_back(b);
      end
   endfunction

   function automatic void add_frame(input logic [31:0] len, input int sent, input bit corrupt);
      logic [31:0] crc;
      logic [7:0]  b;
      crc = CRC_INIT;
      add_marker(4);
      add_word(len);
      for (int i = 0; i < sent; i++) begin
         b = $urandom_range(0, 255);
         crc = crc32_update(crc, b);
         stream.push_back(b);
      end
      if (sent == len) begin
         crc = ~crc;
         if (corrupt) begin
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
         end
         add_word(crc);
      end
   endfunction

   function automatic void add_random_segment();
      int          pick;
      int          cap;
      logic [31:0] len;
      pick = $urandom_range(0, 99);
      cap = (max_cfg < 24) ? int'(max_cfg) : 24;
      if (pick < 70) begin
         if ($urandom_range(0, 3) == 0) begin
            add_noise($urandom_range(1, 3));
         end
         len = $urandom_range(0, cap);
         add_frame(len, len, pick >= 55);
      end else if (pick < 80 && max_cfg != 32'hFFFF_FFFF) begin
         len = $urandom_range(0, 1) ? max_cfg + 32'd1
                                    : max_cfg + 32'd1 + ($urandom() % (32'hFFFF_FFFF - max_cfg));
         add_marker(4);
         add_word(len);
      end else if (pick < 92) begin
         if ($urandom_range(0, 1) == 0) begin
            add_marker($urandom_range(1, 3));
         end
         add_noise($urandom_range(1, 12));
      end else if (cap >= 1) begin
         // payload cut short, the next bytes get swallowed
         len = $urandom_range(1, cap);
         add_frame(len, $urandom_range(0, len - 1), 1'b0);
      end else begin
         add_noise(4);
      end
   endfunction

   initial begin
      int quota;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty payload, crc of nothing
      add_frame(32'd0, 0, 1'b0);
      drain_stream();
      settle();

      // marker on the last allowed byte, crc mismatch, then too large
      write_regs(32'd4, 32'd1);
      add_frame(32'd1, 1, 1'b1);
      add_marker(4);
      add_word(32'h0000_00FF);
      drain_stream();
      settle();

      // zero limit acts as one
      write_regs(32'hFFFF_0000, 32'hFFFF_FFFF);
      stream.push_back(8'h00);
      stream.push_back(8'hFF);
      drain_stream();
      settle();

      for (int round = 0; round < RANDOM_ROUNDS; round++) begin
         case (round)
            0: begin
               write_regs({16'd0, HUNT_LIMIT_RESET}, MAX_LENGTH_RESET);
            end
            1: begin
               write_regs(32'd1, 32'd0);
            end
            2: begin
               write_regs(32'h0000_FFFF, 32'hFFFF_FFFF);
            end
            3: begin
               write_regs(32'd4, 32'd1);
            end
            4: begin
               write_regs($urandom_range(5, 60), $urandom_range(0, 40));
            end
            default: begin
               write_regs($urandom(), $urandom());
            end
         endcase
         quota = bytes_sent + ITEMS / RANDOM_ROUNDS;
         while (bytes_sent < quota) begin
            add_random_segment();
            drain_stream();
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("boot_image_frame_receiver_tb: clean");
      end else begin
         $display("boot_image_frame_receiver_tb: errors");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bfr_pkg.sv
rtl/bfr_crc32_byte.sv
rtl/boot_image_frame_receiver.sv
dv/frame_checker.sv
dv/boot_image_frame_receiver_tb.sv
